@@ rtl/nbr_pkg.sv @@
// ----------------------------------------------------------------------------
// nbr_pkg
// Shared types and constants of the NAL bit reader with Exp-Golomb decoding.
// ----------------------------------------------------------------------------
package nbr_pkg;

	localparam int BUFFER_BYTES_DEF = 4096;
	localparam logic [7:0] EPB_BYTE = 8'h03;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam int MAX_BITS = 32;

	localparam logic [3:0] CMD_LOAD      = 4'd0;
	localparam logic [3:0] CMD_CLEAR     = 4'd1;
	localparam logic [3:0] CMD_REWIND    = 4'd2;
	localparam logic [3:0] CMD_READBITS  = 4'd3;
	localparam logic [3:0] CMD_UE        = 4'd4;
	localparam logic [3:0] CMD_SE        = 4'd5;
	localparam logic [3:0] CMD_SKIPBITS  = 4'd6;
	localparam logic [3:0] CMD_SKIPBYTES = 4'd7;
	localparam logic [3:0] CMD_SEEK      = 4'd8;
	localparam logic [3:0] CMD_ALIGN     = 4'd9;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADCOUNT = 2'd2;
	localparam logic [1:0] ST_PREFIX   = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_EXEC,
		OP_FETCH,
		OP_BIT,
		OP_ESC_A,
		OP_ESC_B,
		OP_ESC_C,
		OP_ESC_D,
		OP_SKB_STEP,
		OP_SKB_END,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic go_read;
		logic go_skip;
		logic p_lt2;
		logic loop_done;
		logic too_long;
		logic cnt_zero;
		logic wrap;
	} dp_status_t;

endpackage

@@ rtl/nal_bit_reader_expgolomb.sv @@
// ----------------------------------------------------------------------------
// nal_bit_reader_expgolomb
// MSB-first bit reader over a loaded NAL byte buffer with Exp-Golomb decoding.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (low to high)              tuser
// s_axis   in         command, byte_value, amount             none
// m_axis   out        value, status, byte_position, bit_index, bytes_left   none
//
// A simple command passes from its latch step through its execute step to the
// result. Each bit read fetches its byte and then takes the bit, with an escape
// byte check whenever the byte position advances (cut short below byte two);
// reads end with a finish step. Each byte stepped by a bit skip runs an escape
// byte check and a position step.
// The byte store has one write port and one registered read port and needs no
// clearing after reset. One transaction is handled at a time; a result holds
// until it is taken.
module nal_bit_reader_expgolomb #(
	parameter int BUFFER_BYTES = nbr_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // command[3:0], byte_value[11:4], amount[27:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // value, status, byte_position, bit_index, bytes_left
);
	import nbr_pkg::*;

	dp_op_t     op;
	dp_status_t st;
	logic [32:0] value;
	logic [1:0]  status;
	logic [12:0] byte_position;
	logic [2:0]  bit_index;
	logic [12:0] bytes_left;

	nbr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.op        (op)
	);

	nbr_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.in_command    (s_axis_tdata[3:0]),
		.in_byte_value (s_axis_tdata[11:4]),
		.in_amount     (s_axis_tdata[27:12]),
		.st            (st),
		.value         (value),
		.status        (status),
		.byte_position (byte_position),
		.bit_index     (bit_index),
		.bytes_left    (bytes_left)
	);

	assign m_axis_tdata = {bytes_left, bit_index, byte_position, status, value};

endmodule

@@ rtl/nbr_datapath.sv @@
// ----------------------------------------------------------------------------
// nbr_datapath
// Byte store, position, bit index, shift register and result registers.
// ----------------------------------------------------------------------------
module nbr_datapath #(
	parameter int BUFFER_BYTES = nbr_pkg::BUFFER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nbr_pkg::dp_op_t    op,
	input  logic [3:0]         in_command,
	input  logic [7:0]         in_byte_value,
	input  logic [15:0]        in_amount,
	output nbr_pkg::dp_status_t st,
	output logic [32:0]        value,
	output logic [1:0]         status,
	output logic [12:0]        byte_position,
	output logic [2:0]         bit_index,
	output logic [12:0]        bytes_left
);
	import nbr_pkg::*;

	localparam int PW = $clog2(BUFFER_BYTES + 3);
	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [PW-1:0] BUF_LEN = PW'(BUFFER_BYTES);

	logic [3:0]        cmd_q;
	logic [7:0]        byte_q;
	logic signed [15:0] amt_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     fill_q;
	logic [2:0]        bit_q;
	logic [12:0]       cnt_q;
	logic [5:0]        zeros_q;
	logic              suffix_q;
	logic [31:0]       sh_q;
	logic [32:0]       val_q;
	logic [1:0]        status_q;
	logic              ok_q;

	logic [7:0]        mem [BUFFER_BYTES];
	logic [7:0]        rd_q;
	logic              rdok_q;

	logic [PW-1:0]     addr_d;
	logic [7:0]        byte_z;
	logic              bit_v;
	logic [PW-1:0]     pos_inc;
	logic [PW-1:0]     esc_pos;
	logic signed [31:0] pos32;
	logic signed [31:0] fill32;
	logic signed [31:0] seek_np;
	logic signed [31:0] skb_np;
	logic [32:0]       code;
	logic              is_golomb;

	assign byte_z    = rdok_q ? rd_q : ZERO_BYTE;
	assign bit_v     = byte_z[3'd7 - bit_q];
	assign pos_inc   = pos_q + PW'(1);
	assign pos32     = $signed(32'(pos_q));
	assign fill32    = $signed(32'(fill_q));
	assign seek_np   = pos32 + 32'(amt_q);
	assign skb_np    = pos32 + ((bit_q != 3'd0) ? 32'sd1 : 32'sd0) + 32'(amt_q);
	assign code      = ((33'd1 << zeros_q) - 33'd1) + {1'b0, sh_q};
	assign is_golomb = (cmd_q == CMD_UE) || (cmd_q == CMD_SE);
	assign esc_pos   = (ok_q && (byte_z == EPB_BYTE)) ? pos_inc : pos_q;

	always_comb begin
		case (op)
			OP_ESC_A: addr_d = pos_q - PW'(2);
			OP_ESC_B: addr_d = pos_q - PW'(1);
			default:  addr_d = pos_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_EXEC && cmd_q == CMD_LOAD && fill_q < BUF_LEN) begin
			mem[fill_q[AW-1:0]] <= byte_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_q   <= mem[addr_d[AW-1:0]];
		rdok_q <= addr_d < fill_q;
	end

	always_comb begin
		st.go_read   = (cmd_q == CMD_READBITS && amt_q >= 0 && amt_q <= 16'sd32) || is_golomb;
		st.go_skip   = (cmd_q == CMD_SKIPBITS) && (amt_q >= 0);
		st.p_lt2     = pos_q < PW'(2);
		st.cnt_zero  = cnt_q == 13'd0;
		st.loop_done = !(is_golomb && !suffix_q) && (cnt_q == 13'd0);
		st.too_long  = zeros_q == 6'(MAX_BITS);
		st.wrap      = bit_q == 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fill_q   <= '0;
			bit_q    <= '0;
			cnt_q    <= '0;
			zeros_q  <= '0;
			suffix_q <= 1'b0;
			sh_q     <= '0;
			status_q <= ST_OK;
			val_q    <= '0;
			ok_q     <= 1'b0;
		end else begin
			case (op)
				OP_EXEC: begin
					val_q    <= '0;
					status_q <= ST_OK;
					sh_q     <= '0;
					zeros_q  <= '0;
					suffix_q <= 1'b0;
					case (cmd_q)
						CMD_LOAD: begin
							if (fill_q < BUF_LEN) fill_q <= fill_q + PW'(1);
							else status_q <= ST_FULL;
						end
						CMD_CLEAR: begin
							fill_q <= '0;
							pos_q  <= '0;
							bit_q  <= '0;
						end
						CMD_REWIND: begin
							pos_q <= '0;
							bit_q <= '0;
						end
						CMD_READBITS: begin
							if (amt_q < 0 || amt_q > 16'sd32) status_q <= ST_BADCOUNT;
							cnt_q <= 13'(amt_q[5:0]);
						end
						CMD_SKIPBITS: begin
							if (amt_q < 0) status_q <= ST_BADCOUNT;
							cnt_q <= 13'(amt_q[14:3]);
						end
						CMD_SKIPBYTES: begin
							if (amt_q < 0) begin
								status_q <= ST_BADCOUNT;
							end else begin
								bit_q <= '0;
								pos_q <= (skb_np > fill32) ? fill_q : PW'(skb_np);
							end
						end
						CMD_SEEK: begin
							bit_q <= '0;
							if (seek_np < 0) pos_q <= '0;
							else if (seek_np > fill32) pos_q <= fill_q;
							else pos_q <= PW'(seek_np);
						end
						CMD_ALIGN: begin
							if (bit_q != 3'd0) begin
								bit_q <= '0;
								pos_q <= (pos_inc > fill_q) ? fill_q : pos_inc;
							end
						end
						default: begin
						end
					endcase
				end
				OP_BIT: begin
					if (is_golomb && !suffix_q) begin
						if (bit_v) begin
							suffix_q <= 1'b1;
							cnt_q    <= 13'(zeros_q);
						end else begin
							zeros_q <= zeros_q + 6'd1;
						end
					end else begin
						sh_q  <= {sh_q[30:0], bit_v};
						cnt_q <= cnt_q - 13'd1;
					end
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) pos_q <= pos_inc;
				end
				OP_ESC_A: begin
					if (pos_q < PW'(2)) begin
						if (pos_q > fill_q) pos_q <= fill_q;
					end
				end
				OP_ESC_B: ok_q <= byte_z == ZERO_BYTE;
				OP_ESC_C: ok_q <= ok_q && (byte_z == ZERO_BYTE);
				OP_ESC_D: pos_q <= (esc_pos > fill_q) ? fill_q : esc_pos;
				OP_SKB_STEP: begin
					pos_q <= pos_inc;
					cnt_q <= cnt_q - 13'd1;
				end
				OP_SKB_END: cnt_q <= 13'(amt_q[2:0]);
				OP_FINISH: begin
					case (cmd_q)
						CMD_READBITS: val_q <= {1'b0, sh_q};
						CMD_UE: begin
							if (zeros_q == 6'(MAX_BITS)) status_q <= ST_PREFIX;
							else val_q <= code;
						end
						CMD_SE: begin
							if (zeros_q == 6'(MAX_BITS)) status_q <= ST_PREFIX;
							else if (code[0]) val_q <= (code + 33'd1) >> 1;
							else val_q <= 33'd0 - (code >> 1);
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_LATCH) begin
			cmd_q  <= in_command;
			byte_q <= in_byte_value;
			amt_q  <= in_amount;
		end
	end

	assign value         = val_q;
	assign status        = status_q;
	assign byte_position = 13'(pos_q);
	assign bit_index     = bit_q;
	assign bytes_left    = 13'(fill_q - pos_q);

endmodule

@@ rtl/nbr_controller.sv @@
// ----------------------------------------------------------------------------
// nbr_controller
// Sequencer for command execution, bit reads and escape byte checks.
// ----------------------------------------------------------------------------
module nbr_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  nbr_pkg::dp_status_t st,
	output nbr_pkg::dp_op_t     op
);
	import nbr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_LOOP, S_BIT, S_ESC_A, S_ESC_B, S_ESC_C, S_ESC_D,
		S_SKB, S_FIN, S_DONE
	} state_t;

	state_t state_q;
	state_t ret_q;

	always_comb begin
		case (state_q)
			S_IDLE:  op = in_valid ? OP_LATCH : OP_NONE;
			S_EXEC:  op = OP_EXEC;
			S_LOOP:  op = (st.too_long || st.loop_done) ? OP_NONE : OP_FETCH;
			S_BIT:   op = OP_BIT;
			S_ESC_A: op = OP_ESC_A;
			S_ESC_B: op = OP_ESC_B;
			S_ESC_C: op = OP_ESC_C;
			S_ESC_D: op = OP_ESC_D;
			S_SKB:   op = st.cnt_zero ? OP_SKB_END : OP_SKB_STEP;
			S_FIN:   op = OP_FINISH;
			default: op = OP_NONE;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_LOOP;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (st.go_read) begin
						state_q <= S_LOOP;
					end else if (st.go_skip) begin
						ret_q   <= S_SKB;
						state_q <= S_ESC_A;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LOOP: begin
					if (st.too_long || st.loop_done) state_q <= S_FIN;
					else state_q <= S_BIT;
				end
				S_BIT: begin
					if (st.wrap) begin
						ret_q   <= S_LOOP;
						state_q <= S_ESC_A;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_ESC_A: state_q <= st.p_lt2 ? ret_q : S_ESC_B;
				S_ESC_B: state_q <= S_ESC_C;
				S_ESC_C: state_q <= S_ESC_D;
				S_ESC_D: state_q <= ret_q;
				S_SKB: begin
					if (st.cnt_zero) begin
						state_q <= S_LOOP;
					end else begin
						ret_q   <= S_SKB;
						state_q <= S_ESC_A;
					end
				end
				S_FIN:  state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
